// ===== sv/ftdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdc_pkg: shared types and codes for the FIR time-domain convolver
// Request action codes, register indexes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ftdc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 16;
   localparam int LEN_W    = 12;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   // request actions
   localparam logic [1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [1:0] ACT_LOAD    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // register indexes
   localparam logic REG_TAP_OFFSET = 1'b0;
   localparam logic REG_MAX_LENGTH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_HOLD  = 4'b1000
   } ftdc_state_type;

   typedef struct packed {
      logic start_sample;
      logic take_other;
      logic issue;
      logic finish;
      logic push_out;
   } ftdc_cmd_type;

   typedef struct packed {
      logic mac_done;
      logic pipe_empty;
      logic out_free;
   } ftdc_stat_type;

endpackage

// ===== sv/fir_time_domain_convolver_unit.sv =====
// ----------------------------------------------------------------------------
// fir_time_domain_convolver_unit: direct-form FIR convolver, Q1.15
// Sample request: accepted in IDLE, then RUN issues one MAC per cycle through
// the coefficient and history RAM ports, FLUSH drains the pipeline and HOLD
// raises rsp_valid once the output register is free. Load, restart and unused
// requests go straight to HOLD. One request in flight; the next is taken in the
// cycle after the result moves out, as HOLD hands over to IDLE. Synchronous reset
// clears control state; a fill count tracks history, so no clearing pass runs.
// ----------------------------------------------------------------------------
module fir_time_domain_convolver_unit import ftdc_pkg::*; #(
   parameter int MAX_TAPS = 2048
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [INDEX_W-1:0]         req_tap_index,
   input  logic signed [SAMPLE_W-1:0] req_tap_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_status,
   output logic [LEN_W-1:0]           rsp_active_taps,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_W-1:0]           csr_pwdata,
   output logic [CSR_W-1:0]           csr_prdata,
   output logic                       csr_pready
);

   logic [INDEX_W-1:0] tap_offset_ff, tap_offset_in;
   logic [LEN_W-1:0]   max_length_ff, max_length_in;
   logic               csr_wr;
   ftdc_cmd_type       cmd;
   ftdc_stat_type      stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      tap_offset_in = tap_offset_ff;
      max_length_in = max_length_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TAP_OFFSET: tap_offset_in = csr_pwdata[INDEX_W-1:0];
            REG_MAX_LENGTH: max_length_in = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TAP_OFFSET: csr_prdata = CSR_W'(tap_offset_ff);
         REG_MAX_LENGTH: csr_prdata = CSR_W'(max_length_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_offset_ff <= '0;
         max_length_ff <= '0;
      end else begin
         tap_offset_ff <= tap_offset_in;
         max_length_ff <= max_length_in;
      end
   end

   ftdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   ftdc_datapath #(.MAX_TAPS(MAX_TAPS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_sample_in   (req_sample_in),
      .req_tap_index   (req_tap_index),
      .req_tap_value   (req_tap_value),
      .tap_offset      (tap_offset_ff),
      .max_length      (max_length_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_status      (rsp_status),
      .rsp_active_taps (rsp_active_taps)
   );

endmodule

// ===== sv/ftdc_ram.sv =====
// ----------------------------------------------------------------------------
// ftdc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ftdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ftdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftdc_ctrl: request sequencer for the convolver
// Accepts a request; for a sample, steps the multiply-accumulate loop and
// drains the pipeline; then hands the result to the output register.
// ----------------------------------------------------------------------------
module ftdc_ctrl import ftdc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_action,
   output logic          req_stall,
   input  ftdc_stat_type stat,
   output ftdc_cmd_type  cmd
);

   ftdc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_SAMPLE) begin
                  cmd.start_sample = 1'b1;
                  state_in         = ST_RUN;
               end else begin
                  cmd.take_other = 1'b1;
                  state_in       = ST_HOLD;
               end
            end
         end
         ST_RUN: begin
            if (stat.mac_done) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (stat.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (stat.out_free) begin
               cmd.push_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== sv/ftdc_datapath.sv =====
// ----------------------------------------------------------------------------
// ftdc_datapath: coefficient and history stores, MAC pipeline, result regs
// A fill count marks how much history is valid since the last clear, so
// the history RAM never needs a clearing sweep.
// ----------------------------------------------------------------------------
module ftdc_datapath import ftdc_pkg::*; #(
   parameter int MAX_TAPS = 2048
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ftdc_cmd_type               cmd,
   output ftdc_stat_type              stat,
   input  logic [1:0]                 req_action,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [INDEX_W-1:0]         req_tap_index,
   input  logic signed [SAMPLE_W-1:0] req_tap_value,
   input  logic [INDEX_W-1:0]         tap_offset,
   input  logic [LEN_W-1:0]           max_length,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_status,
   output logic [LEN_W-1:0]           rsp_active_taps
);

   localparam int AW   = $clog2(MAX_TAPS);
   localparam int CW   = $clog2(MAX_TAPS + 1);
   localparam int PW   = 2 * SAMPLE_W;
   localparam int ACCW = PW + CW;
   localparam int XW   = INDEX_W + 1;

   logic [AW-1:0]               head_ff, head_in;
   logic [AW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]               tap_count_ff, tap_count_in;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [CW-1:0]               k_ff, k_in;
   logic                        clear_ff, clear_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_use_ff, s1_use_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [ACCW-1:0]      acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]  res_sample_ff, res_sample_in;
   logic                        res_status_ff, res_status_in;
   logic [LEN_W-1:0]            res_taps_ff, res_taps_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                        rsp_status_ff;
   logic [LEN_W-1:0]            rsp_taps_ff;

   logic signed [SAMPLE_W-1:0]  coef_rd, hist_rd;
   logic                        coef_wr_en, hist_wr_en;

   logic [INDEX_W-1:0]          pos;
   logic [XW-1:0]               pos_x, cap_x, base_x, load_count_x;
   logic                        in_range, keep, dropped;
   logic [ACCW-31:0]            acc_hi;
   logic                        acc_fits;
   logic signed [SAMPLE_W-1:0]  sat_sample;

   ftdc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (pos[AW-1:0]),
      .wr_data (req_tap_value),
      .rd_en   (cmd.issue),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (coef_rd)
   );

   ftdc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (head_ff),
      .wr_data (req_sample_in),
      .rd_en   (cmd.issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (hist_rd)
   );

   // coefficient load position against the length cap
   always_comb begin
      in_range = (req_tap_index >= tap_offset);
      pos      = req_tap_index - tap_offset;
      pos_x    = {1'b0, pos};
      if (max_length == '0 || XW'(max_length) > XW'(MAX_TAPS)) begin
         cap_x = XW'(MAX_TAPS);
      end else begin
         cap_x = XW'(max_length);
      end
      keep    = in_range && (pos_x < cap_x);
      dropped = in_range && !keep && (max_length == '0);
      // index zero restarts the impulse
      base_x  = (req_tap_index == '0) ? '0 : XW'(tap_count_ff);
      if (keep && (pos_x + XW'(1)) > base_x) begin
         load_count_x = pos_x + XW'(1);
      end else begin
         load_count_x = base_x;
      end
   end

   // floor by 2^15 is a bit select; saturate when the upper bits disagree
   always_comb begin
      acc_hi   = acc_ff[ACCW-1:30];
      acc_fits = (&acc_hi) || !(|acc_hi);
      if (acc_fits) begin
         sat_sample = acc_ff[30:15];
      end else if (acc_ff[ACCW-1]) begin
         sat_sample = 16'sh8000;
      end else begin
         sat_sample = 16'sh7fff;
      end
   end

   always_comb begin
      head_in       = head_ff;
      rd_ptr_in     = rd_ptr_ff;
      tap_count_in  = tap_count_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      clear_in      = clear_ff;
      acc_in        = acc_ff;
      res_sample_in = res_sample_ff;
      res_status_in = res_status_ff;
      res_taps_in   = res_taps_ff;
      coef_wr_en    = 1'b0;
      hist_wr_en    = 1'b0;

      if (cmd.start_sample) begin
         hist_wr_en = 1'b1;
         head_in    = (head_ff == AW'(MAX_TAPS - 1)) ? '0 : head_ff + AW'(1);
         rd_ptr_in  = head_ff;
         k_in       = '0;
         acc_in     = '0;
         clear_in   = 1'b0;
         if (clear_ff) begin
            fill_in = CW'(1);
         end else if (fill_ff != CW'(MAX_TAPS)) begin
            fill_in = fill_ff + CW'(1);
         end
      end

      if (cmd.take_other) begin
         res_sample_in = '0;
         res_status_in = 1'b0;
         res_taps_in   = LEN_W'(tap_count_ff);
         if (req_action == ACT_LOAD) begin
            clear_in      = 1'b1;
            coef_wr_en    = keep;
            tap_count_in  = CW'(load_count_x);
            res_status_in = dropped;
            res_taps_in   = LEN_W'(load_count_x);
         end else if (req_action == ACT_RESTART) begin
            clear_in = 1'b1;
         end
      end

      if (cmd.issue) begin
         k_in      = k_ff + CW'(1);
         rd_ptr_in = (rd_ptr_ff == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_ff - AW'(1);
      end

      if (s2_valid_ff) begin
         acc_in = acc_ff + {{(ACCW - PW){prod_ff[PW-1]}}, prod_ff};
      end

      if (cmd.finish) begin
         res_sample_in = sat_sample;
         res_status_in = 1'b0;
         res_taps_in   = LEN_W'(tap_count_ff);
      end
   end

   // MAC pipeline: address, RAM data, product, accumulate
   always_comb begin
      s1_valid_in = cmd.issue;
      s1_use_in   = (k_ff < fill_ff);
      s2_valid_in = s1_valid_ff;
      prod_in     = '0;
      if (s1_use_ff) begin
         prod_in = coef_rd * hist_rd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tap_count_ff <= '0;
         fill_ff      <= '0;
         clear_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tap_count_ff <= tap_count_in;
         fill_ff      <= fill_in;
         clear_ff     <= clear_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      k_ff          <= k_in;
      s1_use_ff     <= s1_use_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      res_sample_ff <= res_sample_in;
      res_status_ff <= res_status_in;
      res_taps_ff   <= res_taps_in;
      if (cmd.push_out) begin
         rsp_sample_ff <= res_sample_ff;
         rsp_status_ff <= res_status_ff;
         rsp_taps_ff   <= res_taps_ff;
      end
   end

   assign stat.mac_done   = !(k_ff < tap_count_ff);
   assign stat.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_active_taps = rsp_taps_ff;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: FIR time-domain convolver unit
// Streams sample, coefficient load, restart and unused requests through the
// unit with random gaps on both channels and several register settings.
// A scoreboard keeps its own tap store, sample history and Q1.15 MAC and
// checks every response field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ftdc_pkg::*;

   localparam int MAX_TAPS    = 2048;
   localparam int HEAD_W      = $clog2(MAX_TAPS);
   localparam int FILL_TAPS   = 32;
   localparam int PHASE_ITEMS = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 100;

   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       status;
      logic [LEN_W-1:0]           active_taps;
   } fir_result_type;

   class fir_scoreboard;
      logic signed [SAMPLE_W-1:0] taps [MAX_TAPS];
      logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
      logic [HEAD_W-1:0]          write_head;
      int unsigned                tap_count;
      int unsigned                covered;
      bit                         clear_pending;
      logic [INDEX_W-1:0]         tap_offset;
      logic [LEN_W-1:0]           max_length;
      fir_result_type             expected_outputs[$];
      int                         errors;

      function new();
         foreach (taps[i]) begin
            taps[i]    = '0;
            history[i] = '0;
         end
         write_head    = '0;
         tap_count     = 0;
         covered       = 0;
         clear_pending = 1'b1;
         tap_offset    = '0;
         max_length    = '0;
         errors        = 0;
      endfunction

      function void set_register(logic reg_idx, logic [CSR_W-1:0] value);
         if (reg_idx == REG_TAP_OFFSET)
            tap_offset = value[INDEX_W-1:0];
         else
            max_length = value[LEN_W-1:0];
      endfunction

      function int unsigned tap_limit();
         if (max_length == '0 || max_length > MAX_TAPS)
            return MAX_TAPS;
         return max_length;
      endfunction

      // work out the response to one accepted request and queue it
      function void note_request(logic [1:0] action, logic signed [SAMPLE_W-1:0] sample_in,
                                 logic [INDEX_W-1:0] tap_index,
                                 logic signed [SAMPLE_W-1:0] tap_value);
         fir_result_type    r;
         longint            acc;
         longint            y;
         int                k;
         int unsigned       pos;
         logic [HEAD_W-1:0] idx;
         r = '0;
         case (action)
            ACT_SAMPLE: begin
               if (clear_pending) begin
                  foreach (history[i]) history[i] = '0;
                  clear_pending = 1'b0;
               end
               history[write_head] = sample_in;
               acc = 0;
               for (k = 0; k < tap_count; k++) begin
                  idx = write_head - k[HEAD_W-1:0];
                  acc += longint'(taps[k]) * longint'(history[idx]);
               end
               write_head = write_head + 1'b1;
               // arithmetic shift floors; then clamp to Q1.15
               y = acc >>> 15;
               if (y > 32767)
                  y = 32767;
               else if (y < -32768)
                  y = -32768;
               r.sample_out = y[SAMPLE_W-1:0];
            end
            ACT_LOAD: begin
               clear_pending = 1'b1;
               if (tap_index == '0)
                  tap_count = 0;
               if (tap_index >= tap_offset) begin
                  pos = tap_index - tap_offset;
                  if (pos < tap_limit()) begin
                     taps[pos] = tap_value;
                     if (pos == covered)
                        covered++;
                     if (pos + 1 > tap_count)
                        tap_count = pos + 1;
                  end else if (max_length == '0) begin
                     r.status = 1'b1;
                  end
               end
            end
            ACT_RESTART: clear_pending = 1'b1;
            default: ;
         endcase
         r.active_taps = tap_count[LEN_W-1:0];
         expected_outputs.push_back(r);
      endfunction

      function void report(string what, longint want, longint got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      endfunction

      function void check_response(fir_result_type got);
         fir_result_type want;
         if (expected_outputs.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with nothing expected: sample_out %0d status %0d taps %0d",
                        $time, $signed(got.sample_out), got.status, got.active_taps);
            return;
         end
         want = expected_outputs.pop_front();
         if (got.sample_out !== want.sample_out)
            report("sample_out", $signed(want.sample_out), $signed(got.sample_out));
         if (got.status !== want.status)
            report("status", want.status, got.status);
         if (got.active_taps !== want.active_taps)
            report("active_taps", want.active_taps, got.active_taps);
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_action;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic [INDEX_W-1:0]         req_tap_index;
   logic signed [SAMPLE_W-1:0] req_tap_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_status;
   logic [LEN_W-1:0]           rsp_active_taps;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_AW-1:0]          csr_paddr;
   logic [CSR_W-1:0]           csr_pwdata;
   logic [CSR_W-1:0]           csr_prdata;
   logic                       csr_pready;

   fir_scoreboard conv_board = new();
   bit            no_idle;
   int unsigned   next_index;

   fir_time_domain_convolver_unit #(
      .MAX_TAPS(MAX_TAPS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_sample_in  (req_sample_in),
      .req_tap_index  (req_tap_index),
      .req_tap_value  (req_tap_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_status     (rsp_status),
      .rsp_active_taps(rsp_active_taps),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [15:0] rnd16();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // mostly back to back, sometimes short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called and returns at a falling edge
   task automatic send_request(logic [1:0] action, logic signed [SAMPLE_W-1:0] sample_in,
                               logic [INDEX_W-1:0] tap_index,
                               logic signed [SAMPLE_W-1:0] tap_value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action    = action;
      req_sample_in = sample_in;
      req_tap_index = tap_index;
      req_tap_value = tap_value;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall);
      conv_board.note_request(action, sample_in, tap_index, tap_value);
      @(negedge clock);
   endtask

   // mostly streamed impulses: restart at index 0, then consecutive indexes
   task automatic send_random_request(logic [INDEX_W-1:0] offset, logic [LEN_W-1:0] max_len);
      int                         roll;
      int unsigned                idx;
      int unsigned                cap;
      logic [1:0]                 action;
      logic signed [SAMPLE_W-1:0] sample_val;
      logic signed [SAMPLE_W-1:0] tap_val;
      cap        = (max_len == '0 || max_len > MAX_TAPS) ? MAX_TAPS : max_len;
      sample_val = rnd16();
      tap_val    = rnd16();
      if ($urandom_range(0, 9) == 0)
         sample_val = $urandom_range(0, 1) ? Q15_MAX : Q15_MIN;
      if ($urandom_range(0, 9) == 0)
         tap_val = $urandom_range(0, 1) ? Q15_MAX : Q15_MIN;
      idx  = rnd16();
      roll = $urandom_range(0, 99);
      if (roll < 47) begin
         action = ACT_SAMPLE;
      end else if (roll < 87) begin
         action = ACT_LOAD;
         roll   = $urandom_range(0, 99);
         if (roll < 20) begin
            idx        = 0;
            next_index = ($urandom_range(0, 1) && offset != '0) ? offset - 1 : offset;
         end else if (roll < 70) begin
            idx        = next_index;
            next_index = next_index + 1;
         end else if (roll < 74) begin
            idx = offset + $urandom_range(0, MAX_TAPS - 1);
         end else if (roll < 86) begin
            idx = offset + cap - 1 + $urandom_range(0, 2);
         end
         if (idx > 16'hFFFF)
            idx = 16'hFFFF;
         if (next_index > 16'hFFFF)
            next_index = 16'hFFFF;
         // keep stored taps contiguous so no active tap is left unwritten
         if (idx >= offset && idx - offset < cap && idx - offset > conv_board.covered)
            idx = offset + conv_board.covered;
      end else if (roll < 95) begin
         action = ACT_RESTART;
      end else begin
         action = ACT_UNUSED;
      end
      send_request(action, sample_val, idx[INDEX_W-1:0], tap_val);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (conv_board.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // write one register, then read it back
   task automatic write_register(logic reg_idx, logic [CSR_W-1:0] value);
      logic [CSR_W-1:0] readback;
      logic [CSR_W-1:0] want;
      csr_paddr   = {reg_idx, 2'b00};
      csr_pwdata  = value;
      csr_pwrite  = 1'b1;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      conv_board.set_register(reg_idx, value);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      want = (reg_idx == REG_TAP_OFFSET) ? (value & 32'hFFFF) : (value & 32'hFFF);
      if (readback !== want)
         conv_board.report("register readback", want, readback);
   endtask

   initial begin : response_side
      int stall_left;
      int seen;
      fir_result_type got;
      stall_left = 0;
      seen       = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.sample_out  = rsp_sample_out;
            got.status      = rsp_status;
            got.active_taps = rsp_active_taps;
            conv_board.check_response(got);
            seen++;
            // hold off long enough for the unit to back up into its input
            if (seen == 30 || seen == 200)
               stall_left = HOLD_CYCLES;
         end
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall  = 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      #200ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int                 i;
      int                 p;
      logic [INDEX_W-1:0] offset;
      logic [LEN_W-1:0]   max_len;
      req_valid     = 1'b0;
      req_action    = ACT_SAMPLE;
      req_sample_in = '0;
      req_tap_index = '0;
      req_tap_value = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      no_idle       = 1'b0;
      next_index    = 0;
      reset         = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // fresh state: no taps, unused action, bare restart
      send_request(ACT_SAMPLE, 16'sd12345, rnd16(), rnd16());
      send_request(ACT_UNUSED, rnd16(), rnd16(), rnd16());
      send_request(ACT_RESTART, rnd16(), rnd16(), rnd16());

      // fill the leading tap positions with no gaps between requests
      no_idle = 1'b1;
      for (i = 0; i < FILL_TAPS; i++)
         send_request(ACT_LOAD, rnd16(), INDEX_W'(i), (i < 8) ? Q15_MAX : rnd16());
      no_idle = 1'b0;

      // filter driven into both saturation limits
      send_request(ACT_SAMPLE, Q15_MAX, rnd16(), rnd16());
      send_request(ACT_SAMPLE, Q15_MAX, rnd16(), rnd16());
      send_request(ACT_SAMPLE, Q15_MIN, rnd16(), rnd16());
      send_request(ACT_SAMPLE, Q15_MIN, rnd16(), rnd16());
      send_request(ACT_SAMPLE, Q15_MIN, rnd16(), rnd16());
      // past the tap store with no cap set: dropped with status
      send_request(ACT_LOAD, rnd16(), 16'd2048, rnd16());
      send_request(ACT_LOAD, rnd16(), 16'hFFFF, 16'hFFFF);
      send_request(ACT_RESTART, rnd16(), rnd16(), rnd16());
      send_request(ACT_UNUSED, rnd16(), rnd16(), rnd16());
      // new impulse, then a jump that leaves older taps in the gap
      send_request(ACT_LOAD, rnd16(), 16'd0, Q15_MAX);
      send_request(ACT_LOAD, rnd16(), 16'd1, Q15_MIN);
      send_request(ACT_LOAD, rnd16(), 16'd5, rnd16());
      send_request(ACT_SAMPLE, Q15_MIN, rnd16(), rnd16());
      send_request(ACT_SAMPLE, Q15_MAX, rnd16(), rnd16());
      send_request(ACT_SAMPLE, 16'sd0, rnd16(), rnd16());
      send_request(ACT_LOAD, rnd16(), 16'd3, rnd16());
      send_request(ACT_SAMPLE, 16'sd1, rnd16(), rnd16());
      send_request(ACT_SAMPLE, -16'sd1, rnd16(), rnd16());

      // offset skips leading positions, cap drops the tail quietly
      drain();
      write_register(REG_TAP_OFFSET, 32'd4);
      write_register(REG_MAX_LENGTH, 32'd3);
      send_request(ACT_LOAD, rnd16(), 16'd0, rnd16());
      send_request(ACT_LOAD, rnd16(), 16'd4, rnd16());
      send_request(ACT_LOAD, rnd16(), 16'd6, rnd16());
      send_request(ACT_LOAD, rnd16(), 16'd7, rnd16());
      send_request(ACT_SAMPLE, 16'sd100, rnd16(), rnd16());
      send_request(ACT_SAMPLE, rnd16(), rnd16(), rnd16());

      for (p = 0; p < 7; p++) begin
         drain();
         case (p)
            0: begin offset = 16'd0;     max_len = 12'd0;    end
            1: begin offset = 16'd0;     max_len = 12'd2048; end
            2: begin offset = 16'hFFFF;  max_len = 12'd0;    end
            3: begin
               offset  = 16'($urandom_range(1, 16));
               max_len = 12'($urandom_range(1, 24));
            end
            4: begin
               offset  = rnd16();
               max_len = 12'($urandom_range(0, MAX_TAPS));
            end
            5: begin offset = 16'd0;     max_len = 12'd1;    end
            default: begin
               offset  = 16'($urandom_range(0, 3));
               max_len = 12'd0;
            end
         endcase
         write_register(REG_TAP_OFFSET, 32'(offset));
         write_register(REG_MAX_LENGTH, 32'(max_len));
         next_index = offset;
         no_idle    = (p == 3);
         repeat (PHASE_ITEMS) send_random_request(offset, max_len);
      end
      no_idle = 1'b0;
      drain();
      repeat (20) @(negedge clock);

      if (conv_board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
